// ===== src/assert_macros.svh =====
// assertion helpers, sampled on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define CDSQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define CDSQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/cdsq_pkg.sv =====
`default_nettype none

package cdsq_pkg;

  localparam int unsigned PosW = 19;              // sector position width
  localparam int unsigned SumW = PosW + 1;        // sum of two positions
  localparam logic [SumW-1:0] PosLimit = SumW'(450000);
  localparam int unsigned FramesPerSec = 75;
  localparam int unsigned SecsPerMin = 60;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // divide by 75: x * 447393 >> 25 is exact for any 19-bit x
  localparam int unsigned Recip75 = 447393;
  localparam int unsigned R75Shift = 25;
  localparam int unsigned P1W = 2 * PosW;         // product width
  localparam int unsigned SecTotW = P1W - R75Shift; // total seconds width

  // divide by 60: x * 8739 >> 19 is exact for any 13-bit x
  localparam int unsigned Recip60 = 8739;
  localparam int unsigned R60Shift = 19;
  localparam int unsigned R60W = 14;
  localparam int unsigned P2W = SecTotW + R60W;
  localparam int unsigned MinW = P2W - R60Shift;

  typedef struct packed {
    logic              pregap;
    logic [7:0]        ctrl;
    logic [7:0]        trk;
    logic [6:0]        idx;
    logic [PosW-1:0]   len;
    logic [PosW-1:0]   st_trk;
    logic [PosW-1:0]   st_disc;
    logic [PosW-1:0]   off;
  } in_t;

  typedef struct packed {
    logic       err;
    logic [7:0] ctrl;
    logic [7:0] trk;
    logic [7:0] idx;
  } hdr_t;

  typedef struct packed {
    logic [7:0] mn;
    logic [7:0] sc;
    logic [7:0] fr;
  } msf_t;

  typedef struct packed {
    logic        err;
    logic [7:0]  ctrl;
    logic [7:0]  trk;
    logic [7:0]  idx;
    msf_t        rel_pos;
    msf_t        abs_pos;
    logic [15:0] crc;
  } res_t;

  // packed bcd, tens digit truncated to a nibble
  function automatic logic [7:0] bcd_of(input logic [7:0] v);
    logic [4:0] tens;
    logic [7:0] ones;
    tens = '0;
    for (int t = 1; t <= 25; t++) begin
      if (v >= 8'(t * 10)) begin
        tens = 5'(t);
      end
    end
    ones = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
    return {tens[3:0], ones[3:0]};
  endfunction

  // one byte of crc-16, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c_i, input logic [7:0] b_i);
    logic [15:0] c;
    c = c_i ^ {b_i, 8'h00};
    for (int j = 0; j < 8; j++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/cd_subq_frame_generator.sv =====
// a result passes through 8 pipeline stages and then the output register
// throughput: one request per cycle except while stalled; the msf multiplier stages set the depth
// a skid register behind the output register lets the pipeline hold one extra result when stalled
// reset: rst_ni async active low clears all valid bits and sets the track count to 1
`default_nettype none
`include "assert_macros.svh"

module cd_subq_frame_generator import cdsq_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // track count register write
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [6:0]   cfg_data_i,
  // request stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // ctrl/adr byte, track no, index no, index length, start in track,
  // start on disc, offset in index, zero pad
  input  wire logic [103:0] s_axis_tdata,
  // pregap flag
  input  wire logic         s_axis_tuser,
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // control_out, track_bcd, index_bcd, rel_minute_bcd, rel_second_bcd, rel_frame_bcd,
  // abs_minute_bcd, abs_second_bcd, abs_frame_bcd, q_crc
  output logic [87:0]       m_axis_tdata,
  // position_error
  output logic              m_axis_tuser
);

  logic            en;
  logic [6:0]      tc_q;
  in_t             req;
  logic            v2;
  hdr_t            h2;
  logic [PosW-1:0] rel1, abs1;
  msf_t            rel4, abs4;
  logic            v8;
  res_t            res8, res_out;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= 7'd1;
    end else if (cfg_valid_i) begin
      tc_q <= cfg_data_i;
    end
  end

  // unpack the request, lowest field first
  always_comb begin
    req.ctrl    = s_axis_tdata[7:0];
    req.trk     = s_axis_tdata[15:8];
    req.idx     = s_axis_tdata[22:16];
    req.len     = s_axis_tdata[41:23];
    req.st_trk  = s_axis_tdata[60:42];
    req.st_disc = s_axis_tdata[79:61];
    req.off     = s_axis_tdata[98:80];
    req.pregap  = s_axis_tuser;
  end

  // whole pipeline moves together; it stops only while the skid reg is full
  assign s_axis_tready = en;

  // stages 1-2: position sums, range check, track and index bcd
  cdsq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .in_i     (req),
    .tracks_i (tc_q),
    .valid_o  (v2),
    .hdr_o    (h2),
    .rel_o    (rel1),
    .abs_o    (abs1)
  );

  // stages 2-4: min/sec/frame split for each position
  cdsq_msf u_msf_rel (
    .clk_i (clk_i),
    .en_i  (en),
    .pos_i (rel1),
    .msf_o (rel4)
  );

  cdsq_msf u_msf_abs (
    .clk_i (clk_i),
    .en_i  (en),
    .pos_i (abs1),
    .msf_o (abs4)
  );

  // stages 3-8: crc one or two bytes a stage, then finish the frame
  cdsq_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2),
    .hdr_i   (h2),
    .rel_i   (rel4),
    .abs_i   (abs4),
    .valid_o (v8),
    .res_o   (res8)
  );

  // output register plus skid
  cdsq_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8),
    .res_i   (res8),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (res_out),
    .en_o    (en)
  );

  assign m_axis_tdata = {res_out.crc,
                         res_out.abs_pos.fr, res_out.abs_pos.sc, res_out.abs_pos.mn,
                         res_out.rel_pos.fr, res_out.rel_pos.sc, res_out.rel_pos.mn,
                         res_out.idx, res_out.trk, res_out.ctrl};
  assign m_axis_tuser = res_out.err;

  // a full skid register means the output register is full too
  `CDSQ_ASSERT_IMPL(a_skid_implies_out, !s_axis_tready, m_axis_tvalid,
                    "skid holds data while output register is empty")

  // the skid only fills behind a stalled output
  `CDSQ_ASSERT_IMPL(a_skid_fill_on_stall, $fell(s_axis_tready),
                    $past(m_axis_tvalid && !m_axis_tready),
                    "skid filled without an output stall")

  // a position error blanks every other field
  `CDSQ_ASSERT_IMPL(a_error_blanks, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 88'h0,
                    "error result carries nonzero data")

endmodule

`default_nettype wire

// ===== src/cdsq_front.sv =====
`default_nettype none

module cdsq_front import cdsq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire in_t             in_i,
  input  wire logic [6:0]      tracks_i,
  output logic                 valid_o,
  output hdr_t                 hdr_o,
  output logic [PosW-1:0]      rel_o,
  output logic [PosW-1:0]      abs_o
);

  logic            v1_q, v2_q;
  logic [SumW-1:0] rel_d, rel_q, abs_d, abs_q;
  logic            perr_d, perr_q;
  hdr_t            h1_d, h1_q, h2_d, h2_q;

  always_comb begin
    if (in_i.pregap) begin
      rel_d = SumW'(in_i.len) - SumW'(in_i.off) - SumW'(1);
    end else begin
      rel_d = SumW'(in_i.st_trk) + SumW'(in_i.off);
    end
    abs_d  = SumW'(in_i.st_disc) + SumW'(in_i.off);
    perr_d = in_i.pregap && (in_i.off >= in_i.len);
    h1_d.err  = 1'b0;
    h1_d.ctrl = in_i.ctrl;
    // lead-out and other out-of-range tracks go through raw
    h1_d.trk  = (in_i.trk <= {1'b0, tracks_i}) ? bcd_of(in_i.trk) : in_i.trk;
    h1_d.idx  = bcd_of({1'b0, in_i.idx});
  end

  always_comb begin
    h2_d     = h1_q;
    h2_d.err = perr_q || (rel_q >= PosLimit) || (abs_q >= PosLimit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rel_q  <= rel_d;
      abs_q  <= abs_d;
      perr_q <= perr_d;
      h1_q   <= h1_d;
      h2_q   <= h2_d;
    end
  end

  assign valid_o = v2_q;
  assign hdr_o   = h2_q;
  assign rel_o   = rel_q[PosW-1:0];
  assign abs_o   = abs_q[PosW-1:0];

endmodule

`default_nettype wire

// ===== src/cdsq_msf.sv =====
`default_nettype none

module cdsq_msf import cdsq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [PosW-1:0] pos_i,
  output msf_t                 msf_o
);

  logic [PosW-1:0]    pos2_q;
  logic [P1W-1:0]     p1_q;
  logic [SecTotW-1:0] sec_tot;
  logic [PosW-1:0]    frm_full;
  logic [SecTotW-1:0] sec3_q;
  logic [7:0]         fr3_q;
  logic [P2W-1:0]     p2_q;
  logic [MinW-1:0]    mn;
  logic [SecTotW-1:0] sec_full;
  msf_t               msf_q;

  // stage 2: reciprocal multiply for the frame split
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos2_q <= pos_i;
      p1_q   <= P1W'(pos_i) * P1W'(Recip75);
    end
  end

  // stage 3: frame remainder, reciprocal multiply for the minute split
  always_comb begin
    sec_tot  = p1_q[P1W-1 -: SecTotW];
    frm_full = pos2_q - PosW'(sec_tot) * PosW'(FramesPerSec);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec3_q <= sec_tot;
      fr3_q  <= bcd_of(8'(frm_full[6:0]));
      p2_q   <= P2W'(sec_tot) * P2W'(Recip60);
    end
  end

  // stage 4: second remainder and bcd
  always_comb begin
    mn       = p2_q[P2W-1 -: MinW];
    sec_full = sec3_q - SecTotW'(mn) * SecTotW'(SecsPerMin);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      msf_q.mn <= bcd_of(mn);
      msf_q.sc <= bcd_of(8'(sec_full[5:0]));
      msf_q.fr <= fr3_q;
    end
  end

  assign msf_o = msf_q;

endmodule

`default_nettype wire

// ===== src/cdsq_crc.sv =====
`default_nettype none

module cdsq_crc import cdsq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire hdr_t  hdr_i,
  input  wire msf_t  rel_i,
  input  wire msf_t  abs_i,
  output logic       valid_o,
  output res_t       res_o
);

  logic [5:0]  vld_q;
  hdr_t        h3_q, h4_q, h5_q, h6_q, h7_q;
  msf_t        rel5_q, rel6_q, rel7_q;
  msf_t        abs5_q, abs6_q, abs7_q;
  logic [15:0] c3_q, c4_q, c5_q, c6_q, c7_q;
  logic [15:0] c8;
  res_t        res_d, res_q;

  // stage 8: last byte, invert, swap, blank on error
  always_comb begin
    c8 = crc_byte(c7_q, abs7_q.fr);
    res_d.err     = h7_q.err;
    res_d.ctrl    = h7_q.ctrl;
    res_d.trk     = h7_q.trk;
    res_d.idx     = h7_q.idx;
    res_d.rel_pos = rel7_q;
    res_d.abs_pos = abs7_q;
    res_d.crc     = {~c8[7:0], ~c8[15:8]};
    if (h7_q.err) begin
      res_d     = '0;
      res_d.err = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 3: control and track bytes
      h3_q   <= hdr_i;
      c3_q   <= crc_byte(crc_byte(16'h0000, hdr_i.ctrl), hdr_i.trk);
      // stage 4: index byte
      h4_q   <= h3_q;
      c4_q   <= crc_byte(c3_q, h3_q.idx);
      // stage 5: relative minute and second
      h5_q   <= h4_q;
      rel5_q <= rel_i;
      abs5_q <= abs_i;
      c5_q   <= crc_byte(crc_byte(c4_q, rel_i.mn), rel_i.sc);
      // stage 6: relative frame and the reserved zero byte
      h6_q   <= h5_q;
      rel6_q <= rel5_q;
      abs6_q <= abs5_q;
      c6_q   <= crc_byte(crc_byte(c5_q, rel5_q.fr), 8'h00);
      // stage 7: absolute minute and second
      h7_q   <= h6_q;
      rel7_q <= rel6_q;
      abs7_q <= abs6_q;
      c7_q   <= crc_byte(crc_byte(c6_q, abs6_q.mn), abs6_q.sc);
      res_q  <= res_d;
    end
  end

  assign valid_o = vld_q[5];
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== src/cdsq_obuf.sv =====
`default_nettype none

module cdsq_obuf import cdsq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire res_t  res_i,
  input  wire logic  ready_i,
  output logic       valid_o,
  output res_t       res_o,
  output logic       en_o
);

  logic out_v_q, sk_v_q;
  res_t out_q, sk_q;
  logic take;

  assign take = !out_v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (take) begin
      out_v_q <= sk_v_q ? 1'b1 : valid_i;
      sk_v_q  <= 1'b0;
    end else if (valid_i && !sk_v_q) begin
      sk_v_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= sk_v_q ? sk_q : res_i;
    end
    if (!take && !sk_v_q) begin
      sk_q <= res_i;
    end
  end

  assign valid_o = out_v_q;
  assign res_o   = out_q;
  assign en_o    = !sk_v_q;

endmodule

`default_nettype wire

// ===== tb/cdsq_frame_checker.sv =====
`timescale 1ns / 100ps

module cdsq_frame_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [6:0]   cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  // ctrl/adr byte, track no, index no, index length, start in track,
  // start on disc, offset in index, zero pad
  input  logic [103:0] s_tdata_i,
  // pregap flag
  input  logic         s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  // control_out, track_bcd, index_bcd, rel min/sec/frame, abs min/sec/frame, q_crc
  input  logic [87:0]  m_tdata_i,
  // position_error
  input  logic         m_tuser_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int unsigned SectorLimit = 450000;
  localparam int unsigned FramesPerSec = 75;
  localparam int unsigned SecsPerMin = 60;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // packed so that {tuser, tdata} maps onto it directly
  typedef struct packed {
    logic        err;
    logic [15:0] crc;
    logic [7:0]  abs_f;
    logic [7:0]  abs_s;
    logic [7:0]  abs_m;
    logic [7:0]  rel_f;
    logic [7:0]  rel_s;
    logic [7:0]  rel_m;
    logic [7:0]  idx;
    logic [7:0]  trk;
    logic [7:0]  ctrl;
  } q_frame_t;

  q_frame_t   expected_frames[$];
  logic [6:0] tracks_q;

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // {minute, second, frame}, each in packed bcd
  function automatic logic [23:0] sector_msf(input int unsigned sector);
    int unsigned rest;
    logic [7:0]  fr;
    logic [7:0]  sc;
    fr = to_bcd(sector % FramesPerSec);
    rest = sector / FramesPerSec;
    sc = to_bcd(rest % SecsPerMin);
    rest = rest / SecsPerMin;
    return {to_bcd(rest), sc, fr};
  endfunction

  // crc-16 msb first over ten bytes, first byte in the top bits, then inverted and swapped
  function automatic logic [15:0] q_crc(input logic [79:0] bytes);
    logic [15:0] c;
    c = '0;
    for (int k = 0; k < 10; k++) begin
      c ^= {bytes[79 - 8 * k -: 8], 8'h00};
      for (int j = 0; j < 8; j++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
      end
    end
    c = ~c;
    return {c[7:0], c[15:8]};
  endfunction

  function automatic q_frame_t predict_frame(input logic [103:0] d, input logic pregap,
                                             input logic [6:0] count);
    q_frame_t    f;
    int unsigned len;
    int unsigned st_trk;
    int unsigned st_disc;
    int unsigned off;
    int unsigned rel;
    int unsigned abs_pos;
    f = '0;
    len = 32'(d[41:23]);
    st_trk = 32'(d[60:42]);
    st_disc = 32'(d[79:61]);
    off = 32'(d[98:80]);
    abs_pos = st_disc + off;
    rel = 0;
    if (pregap) begin
      if (off >= len) begin
        f.err = 1'b1;
      end else begin
        rel = len - off - 1;
      end
    end else begin
      rel = st_trk + off;
    end
    if (rel >= SectorLimit || abs_pos >= SectorLimit) begin
      f.err = 1'b1;
    end
    // an out of range position zeroes everything else
    if (f.err) begin
      return f;
    end
    f.ctrl = d[7:0];
    f.trk = (d[15:8] <= {1'b0, count}) ? to_bcd(32'(d[15:8])) : d[15:8];
    f.idx = to_bcd(32'(d[22:16]));
    {f.rel_m, f.rel_s, f.rel_f} = sector_msf(rel);
    {f.abs_m, f.abs_s, f.abs_f} = sector_msf(abs_pos);
    f.crc = q_crc({f.ctrl, f.trk, f.idx, f.rel_m, f.rel_s, f.rel_f, 8'h00,
                   f.abs_m, f.abs_s, f.abs_f});
    return f;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    q_frame_t want;
    q_frame_t got;
    if (!rst_ni) begin
      tracks_q = 7'd1;
      expected_frames.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        tracks_q = cfg_data_i;
      end
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tuser_i, m_tdata_i};
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got %h", $time, got);
          fail_count_o++;
        end else begin
          want = expected_frames.pop_front();
          check_field("control_out", 16'(want.ctrl), 16'(got.ctrl));
          check_field("track_bcd", 16'(want.trk), 16'(got.trk));
          check_field("index_bcd", 16'(want.idx), 16'(got.idx));
          check_field("rel_minute_bcd", 16'(want.rel_m), 16'(got.rel_m));
          check_field("rel_second_bcd", 16'(want.rel_s), 16'(got.rel_s));
          check_field("rel_frame_bcd", 16'(want.rel_f), 16'(got.rel_f));
          check_field("abs_minute_bcd", 16'(want.abs_m), 16'(got.abs_m));
          check_field("abs_second_bcd", 16'(want.abs_s), 16'(got.abs_s));
          check_field("abs_frame_bcd", 16'(want.abs_f), 16'(got.abs_f));
          check_field("q_crc", want.crc, got.crc);
          check_field("position_error", 16'(want.err), 16'(got.err));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_frames.push_back(predict_frame(s_tdata_i, s_tuser_i, tracks_q));
      end
    end
    pending_o = expected_frames.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LastSector = 449999;
  localparam int unsigned CycleLimit = 400000;
  // idle margin kept after the last pending frame has drained
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned RequestsPerPhase = 160;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [6:0]   cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tuser;

  int          fail_count;
  int          pending_frames;
  int unsigned cycle_count = 0;
  int unsigned tracks_now;    // local copy, used to aim track numbers at the bcd/raw boundary
  bit          no_gap_run;    // set for stretches of back-to-back requests

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cd_subq_frame_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  cdsq_frame_checker frame_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending_frames)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // idle cycles before a request: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gap_run || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 50);
  endfunction

  // sector value biased toward the ends of the range and small numbers
  function automatic logic [18:0] pick_sector();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0: return 19'd0;
        1: return 19'd1;
        2: return 19'(LastSector - 1);
        default: return 19'(LastSector);
      endcase
    end else if (r < 45) begin
      return 19'($urandom_range(0, 300));
    end
    return 19'($urandom_range(0, LastSector));
  endfunction

  // one request, preceded by a random gap; valid stays high after the handshake
  // so the next request can follow without a bubble
  task automatic push_request(input logic [7:0] ctrl, input logic [7:0] trk,
                              input logic [6:0] idx, input logic pregap,
                              input logic [18:0] len, input logic [18:0] st_trk,
                              input logic [18:0] st_disc, input logic [18:0] off);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {5'b00000, off, st_disc, st_trk, len, idx, trk, ctrl};
    s_axis_tuser = pregap;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mostly well-formed positions with random content, some out of range
  task automatic random_request();
    logic [7:0]  trk;
    logic [18:0] len;
    logic [18:0] st_trk;
    logic [18:0] st_disc;
    logic [18:0] off;
    logic        pregap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      trk = 8'($urandom_range(1, 99));
    end else if (r < 70) begin
      trk = 8'd170;   // lead-out
    end else if (r < 85) begin
      trk = 8'(tracks_now - 1 + $urandom_range(0, 2));
    end else begin
      trk = 8'($urandom_range(0, 255));
    end
    pregap = 1'($urandom_range(0, 1));
    len = pick_sector();
    st_trk = pick_sector();
    if (pregap) begin
      // off inside the pregap most of the time
      if (len != 0 && $urandom_range(0, 9) != 0) begin
        off = 19'($urandom_range(0, len - 1));
      end else begin
        off = 19'($urandom_range(len, LastSector));
      end
    end else if ($urandom_range(0, 9) != 0) begin
      off = 19'($urandom_range(0, LastSector - st_trk));
    end else begin
      off = pick_sector();
    end
    if ($urandom_range(0, 9) != 0) begin
      st_disc = 19'($urandom_range(0, LastSector - off));
    end else begin
      st_disc = pick_sector();
    end
    push_request(8'($urandom_range(0, 255)), trk, 7'($urandom_range(0, 99)), pregap,
                 len, st_trk, st_disc, off);
  endtask

  // drop valid, then let every outstanding frame drain
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_frames != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_track_count(input int unsigned value);
    @(negedge clk_i);
    cfg_data = 7'(value);
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    tracks_now = value;
  endtask

  // result side: alternating ready and stall stretches
  initial begin : ready_gen
    int unsigned hold;
    int unsigned r;
    m_axis_tready = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        m_axis_tready = !m_axis_tready;
        if (m_axis_tready) begin
          hold = (r < 15) ? $urandom_range(100, 300) : $urandom_range(0, 8);
        end else if (r < 70) begin
          hold = $urandom_range(0, 2);
        end else if (r < 95) begin
          hold = $urandom_range(3, 10);
        end else begin
          hold = $urandom_range(20, 60);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    tracks_now = 1;
    no_gap_run = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // track count at its reset value of 1
    push_request(8'h00, 8'd0, 7'd0, 1'b0, 19'd0, 19'd0, 19'd0, 19'd0);
    // highest legal positions, track equal to the count
    push_request(8'hFF, 8'd1, 7'd99, 1'b0, 19'(LastSector), 19'(LastSector),
                 19'(LastSector), 19'd0);
    // relative position one past the limit
    push_request(8'h41, 8'd2, 7'd1, 1'b0, 19'd0, 19'(LastSector), 19'd0, 19'd1);
    // absolute position one past the limit
    push_request(8'h01, 8'd1, 7'd1, 1'b0, 19'd0, 19'd0, 19'(LastSector), 19'd1);
    // pregap: last sector counts down to zero
    push_request(8'h01, 8'd1, 7'd0, 1'b1, 19'd10, 19'd0, 19'd150, 19'd9);
    // pregap: offset equal to the length
    push_request(8'h01, 8'd1, 7'd0, 1'b1, 19'd10, 19'd0, 19'd150, 19'd10);
    // pregap of zero length
    push_request(8'h01, 8'd1, 7'd0, 1'b1, 19'd0, 19'd0, 19'd0, 19'd0);
    // longest pregap, first sector
    push_request(8'h11, 8'd1, 7'd0, 1'b1, 19'(LastSector), 19'd0, 19'd0, 19'd0);
    // lead-out, positions at 0:59:74
    push_request(8'h01, 8'd170, 7'd1, 1'b0, 19'd1000, 19'd4499, 19'd4499, 19'd0);
    // both sums far past the limit
    push_request(8'h80, 8'd255, 7'd64, 1'b0, 19'd0, 19'(LastSector), 19'(LastSector),
                 19'(LastSector));
    // track above the count passes raw, seconds and minutes roll over
    push_request(8'h21, 8'd2, 7'd10, 1'b0, 19'd0, 19'd74, 19'd4499, 19'd1);

    wait_idle();
    write_track_count(99);
    push_request(8'h01, 8'd99, 7'd99, 1'b0, 19'd0, 19'd12345, 19'd54321, 19'd7);
    push_request(8'h01, 8'd100, 7'd2, 1'b0, 19'd0, 19'd0, 19'd0, 19'd0);
    push_request(8'h01, 8'd170, 7'd1, 1'b0, 19'd0, 19'd150, 19'd300000, 19'd75);
    push_request(8'h41, 8'd42, 7'd0, 1'b1, 19'd300, 19'd0, 19'd6000, 19'd0);
    push_request(8'h01, 8'd0, 7'd0, 1'b0, 19'd0, 19'd0, 19'd0, 19'd449);

    // count beyond 99: bcd of values above 99 truncates to 8 bits
    wait_idle();
    write_track_count(127);
    push_request(8'h01, 8'd120, 7'd5, 1'b0, 19'd0, 19'd100, 19'd200, 19'd3);
    push_request(8'h01, 8'd127, 7'd6, 1'b0, 19'd0, 19'd100, 19'd200, 19'd3);
    push_request(8'h01, 8'd100, 7'd7, 1'b0, 19'd0, 19'd100, 19'd200, 19'd3);
    push_request(8'h01, 8'd128, 7'd8, 1'b0, 19'd0, 19'd100, 19'd200, 19'd3);

    for (int p = 0; p < RandomPhases; p++) begin
      wait_idle();
      case (p)
        0: write_track_count(1);
        1: write_track_count(99);
        default: write_track_count($urandom_range(1, 99));
      endcase
      for (int n = 0; n < RequestsPerPhase; n++) begin
        if (n % 40 == 0) begin
          no_gap_run = ($urandom_range(0, 3) == 0);
        end
        random_request();
      end
    end

    wait_idle();
    if (fail_count == 0 && pending_frames == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
